// ===== hw/rtl/lcfd_pkg.sv =====
// Shared types, constants and the CRC-32 byte step for the frame deframer.
`default_nettype none
package lcfd_pkg;

  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned CRC_BYTES  = 4;
  localparam int unsigned MIN_FRAME  = 9;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;  // reflected 0x04C11DB7
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;
  localparam logic [6:0]  MAX_LEN_RESET = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HDR,
    S_LEN,
    S_CRC,
    S_FCS,
    S_CMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic init;
    logic update;
  } crc_ctl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int b = 0; b < 8; b++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lcfd_if.sv =====
// Valid/ready channel interfaces for received bytes and payload beats.
`default_nettype none
interface lcfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcfd_pay_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic       last_of_frame;
  modport source (output valid, output payload_byte, output payload_index,
                  output last_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input payload_index,
                  input last_of_frame, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lcfd_crc.sv =====
// CRC-32 accumulator, one byte per update.
`default_nettype none
module lcfd_crc (
  input  wire logic              clk,
  input  wire lcfd_pkg::crc_ctl_t ctl,
  input  wire logic [7:0]        data,
  output logic [31:0]            crc
);
  import lcfd_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_INIT;
    end else if (ctl.update) begin
      crc <= crc_byte(crc, data);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/length_crc32_frame_deframer.sv =====
// Top level: length-prefixed CRC-32 frame deframer around a byte ring buffer.
`default_nettype none
// Received bytes go into a ring buffer of BUFFER_BYTES bytes held in one
// synchronous RAM. After each byte the sequencer scans from the oldest byte:
// it reads the 4-byte big-endian length, rejects it if outside 9..max
// (max = min(max_frame_length, BUFFER_BYTES)), waits if the frame is not yet
// all held, else runs CRC-32 over length-4 bytes and compares the trailing
// 4-byte CRC. A reject drops one byte and rescans; a good frame streams its
// payload bytes out, then is dropped whole. Every buffer access is a RAM read:
// the address is issued, then the data is taken from the registered RAM output.
// A new byte is taken only when the scan has settled. The user must write
// max_frame_length only while the block is idle; the block does not enforce it.
module length_crc32_frame_deframer #(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_data,
  lcfd_rx_if.sink         rx,
  lcfd_pay_if.source      payload
);
  import lcfd_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW:0]   BUF_SUM = (CW+1)'(BUFFER_BYTES);
  localparam logic [CW-1:0] BUF_CNT = CW'(BUFFER_BYTES);
  localparam logic [31:0]   BUF_32  = 32'(BUFFER_BYTES);

  // ring index wrap: a below the depth and b at most the depth, so one subtract suffices
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= BUF_SUM) begin
      s = s - BUF_SUM;
    end
    return AW'(s);
  endfunction

  state_t state, state_next;

  logic [6:0]    max_frame_length;
  logic [AW-1:0] head;
  logic [CW-1:0] held;
  logic [CW-1:0] off;      // frame offset of the current read
  logic          rd_wait;  // read issued, data arrives this cycle
  logic [31:0]   len_word;
  logic [CW-1:0] len;
  logic [31:0]   fcs;

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    mem_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  crc_ctl_t      crc_ctl;
  logic [31:0]   crc;

  logic          in_beat, out_free, len_bad, frame_short, crc_ok;
  logic          hdr_done, crc_done, fcs_done, emit_beat, emit_last;
  logic [31:0]   eff_max;

  // ---------------- byte buffer ----------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= rx.rx_byte;
    end
    mem_q <= mem[rd_addr];
  end

  lcfd_crc u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (mem_q),
    .crc  (crc)
  );

  // ---------------- decode of the current step ----------------
  assign eff_max     = (32'(max_frame_length) > BUF_32) ? BUF_32 : 32'(max_frame_length);
  assign len_bad     = (len_word < 32'(MIN_FRAME)) || (len_word > eff_max);
  // checked in S_LEN, before len is loaded, so compare against the raw header
  assign frame_short = 32'(held) < len_word;
  assign crc_ok      = (crc ^ CRC_XOROUT) == fcs;
  assign out_free    = !payload.valid || payload.ready;
  assign rd_addr     = wrap_add(head, off);
  assign wr_addr     = (held == BUF_CNT) ? head : wrap_add(head, held);
  assign hdr_done    = rd_wait && (off == CW'(HDR_BYTES - 1));
  assign crc_done    = rd_wait && (off == len - CW'(CRC_BYTES + 1));
  assign fcs_done    = rd_wait && (off == len - CW'(1));
  assign emit_beat   = (state == S_EMIT) && rd_wait && out_free;
  assign emit_last   = off == len - CW'(CRC_BYTES + 1);

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    rx.ready       = 1'b0;
    wr_en          = 1'b0;
    crc_ctl.init   = 1'b0;
    crc_ctl.update = 1'b0;
    case (state)
      S_IDLE: begin
        // no byte taken while reset is held
        rx.ready = !rst;
        wr_en    = rx.valid && !rst;
      end
      S_LEN:   crc_ctl.init   = 1'b1;
      S_CRC:   crc_ctl.update = rd_wait;
      default: ;
    endcase
  end
  assign in_beat = rx.valid && rx.ready;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_beat) state_next = S_SCAN;
      S_SCAN: state_next = (held < CW'(HDR_BYTES)) ? S_IDLE : S_HDR;
      S_HDR:  if (hdr_done) state_next = S_LEN;
      S_LEN: begin
        if (len_bad)          state_next = S_SCAN;
        else if (frame_short) state_next = S_IDLE;
        else                  state_next = S_CRC;
      end
      S_CRC:  if (crc_done) state_next = S_FCS;
      S_FCS:  if (fcs_done) state_next = S_CMP;
      S_CMP:  state_next = crc_ok ? S_EMIT : S_SCAN;
      S_EMIT: if (emit_beat && emit_last) state_next = S_SCAN;
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      max_frame_length <= MAX_LEN_RESET;
      head             <= '0;
      held             <= '0;
      rd_wait          <= 1'b0;
      payload.valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        max_frame_length <= cfg_data;
      end
      // buffer occupancy
      if (in_beat) begin
        if (held == BUF_CNT) begin
          head <= wrap_add(head, CW'(1));       // full: oldest byte overwritten
        end else begin
          held <= held + CW'(1);
        end
      end else if ((state == S_LEN && len_bad) || (state == S_CMP && !crc_ok)) begin
        head <= wrap_add(head, CW'(1));
        held <= held - CW'(1);
      end else if (emit_beat && emit_last) begin
        head <= wrap_add(head, len);
        held <= held - len;
      end
      // read phase toggles in the header, CRC and FCS states; emit waits on the output
      if (state == S_HDR || state == S_CRC || state == S_FCS) begin
        rd_wait <= !rd_wait;
      end else if (state == S_EMIT) begin
        rd_wait <= rd_wait ? !out_free : 1'b1;
      end else begin
        rd_wait <= 1'b0;
      end
      if (emit_beat) begin
        payload.valid <= 1'b1;
      end else if (payload.ready) begin
        payload.valid <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    case (state)
      S_SCAN: off <= '0;
      S_HDR: if (rd_wait) begin
        len_word <= {len_word[23:0], mem_q};
        off      <= off + CW'(1);
      end
      S_LEN: begin
        len <= CW'(len_word);
        off <= '0;
      end
      S_CRC: if (rd_wait) off <= off + CW'(1);
      S_FCS: if (rd_wait) begin
        fcs <= {fcs[23:0], mem_q};
        off <= off + CW'(1);
      end
      S_CMP: off <= CW'(HDR_BYTES);
      S_EMIT: if (emit_beat) begin
        payload.payload_byte  <= mem_q;
        payload.payload_index <= 6'(off - CW'(HDR_BYTES));
        payload.last_of_frame <= emit_last;
        off                   <= off + CW'(1);
      end
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= BUF_CNT) else $error("buffer occupancy above depth");

  a_emit_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (len >= CW'(MIN_FRAME)) && (len <= held))
    else $error("emitting a frame that is not fully held");

  a_beat_scan: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == S_SCAN)) else $error("byte taken without a rescan");

  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    emit_beat |-> (off >= CW'(HDR_BYTES)) && (off < len - CW'(CRC_BYTES)))
    else $error("payload read outside the frame body");

endmodule
`default_nettype wire

// ===== sim/length_crc32_frame_deframer_checker.sv =====
// Payload predictor and scoreboard for the length/CRC-32 frame deframer.
`default_nettype none
module length_crc32_frame_deframer_checker #(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_data,
  input  wire logic       rx_valid,
  input  wire logic       rx_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       pay_valid,
  input  wire logic       pay_ready,
  input  wire logic [7:0] pay_byte,
  input  wire logic [5:0] pay_index,
  input  wire logic       pay_last,
  output int              fail_count,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcfd_pkg::*;

  localparam int unsigned DUE_DEPTH = 256;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] index;
    logic       last;
  } payload_beat_t;

  logic [7:0]    ring_mem [BUFFER_BYTES];
  int unsigned   ring_head;
  int unsigned   ring_cnt;
  payload_beat_t due_mem [DUE_DEPTH];
  int unsigned   due_wr;
  int unsigned   due_rd;
  logic [6:0]    max_len;

  function automatic logic [7:0] held_at(input int unsigned off);
    return ring_mem[(ring_head + off) % BUFFER_BYTES];
  endfunction

  function automatic void drop_bytes(input int unsigned n);
    int unsigned k;
    k = (n > ring_cnt) ? ring_cnt : n;
    ring_head = (ring_head + k) % BUFFER_BYTES;
    ring_cnt  = ring_cnt - k;
  endfunction

  function automatic void due_add(input payload_beat_t pb);
    due_mem[due_wr % DUE_DEPTH] = pb;
    due_wr++;
  endfunction

  function automatic logic [31:0] frame_crc(input int unsigned n);
    logic [31:0] c;
    c = CRC_INIT;
    for (int unsigned i = 0; i < n; i++) begin
      c = c ^ {24'd0, held_at(i)};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c ^ CRC_XOROUT;
  endfunction

  function automatic logic [31:0] be_word(input int unsigned off);
    return {held_at(off), held_at(off+1), held_at(off+2), held_at(off+3)};
  endfunction

  // Append one byte, then hunt for frames exactly as the block does.
  task automatic take_byte(input logic [7:0] b);
    logic [31:0]  flen;
    int unsigned  eff_max, plen;
    payload_beat_t pb;
    eff_max = (max_len > BUFFER_BYTES) ? BUFFER_BYTES : max_len;
    if (ring_cnt >= BUFFER_BYTES) drop_bytes(1);
    ring_mem[(ring_head + ring_cnt) % BUFFER_BYTES] = b;
    ring_cnt++;
    while (ring_cnt >= HDR_BYTES) begin
      flen = be_word(0);
      if (flen < MIN_FRAME || flen > eff_max) begin
        drop_bytes(1);
        continue;
      end
      if (ring_cnt < flen) break;
      if (frame_crc(flen - CRC_BYTES) != be_word(flen - CRC_BYTES)) begin
        drop_bytes(1);
        continue;
      end
      plen = flen - HDR_BYTES - CRC_BYTES;
      for (int unsigned i = 0; i < plen; i++) begin
        pb.data  = held_at(HDR_BYTES + i);
        pb.index = i[5:0];
        pb.last  = (i + 1 == plen);
        due_add(pb);
      end
      drop_bytes(flen);
    end
  endtask

  always @(posedge clk) begin
    payload_beat_t want;
    if (rst) begin
      ring_head  = 0;
      ring_cnt   = 0;
      due_wr     = 0;
      due_rd     = 0;
      fail_count = 0;
      max_len <= MAX_LEN_RESET;
    end else begin
      if (cfg_we) max_len <= cfg_data;
      if (rx_valid && rx_ready) take_byte(rx_byte);
      if (pay_valid && pay_ready) begin
        if (due_wr == due_rd) begin
          $display("%0t: unexpected payload beat %h idx %0d last %0b",
                   $time, pay_byte, pay_index, pay_last);
          fail_count++;
        end else begin
          want = due_mem[due_rd % DUE_DEPTH];
          due_rd++;
          if (want != {pay_byte, pay_index, pay_last}) begin
            $display("%0t: payload mismatch expected byte %h idx %0d last %0b, got %h %0d %0b",
                     $time, want.data, want.index, want.last, pay_byte, pay_index, pay_last);
            fail_count++;
          end
        end
      end
    end
    pending = int'(due_wr - due_rd);
  end
endmodule
`default_nettype wire

// ===== sim/length_crc32_frame_deframer_tb.sv =====
// Testbench top: frame stimulus, output backpressure and the verdict.
`default_nettype none
module length_crc32_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcfd_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [6:0] cfg_data;
  int         fail_count;
  int         pending;
  int         src_idle;     // percent of beats the sender sits out
  int         snk_idle;     // percent of cycles the receiver holds ready low
  int         hold_asked;   // long stalls requested of the receiver
  int         hold_done;    // long stalls the receiver has finished
  int         sent_bytes;
  logic [6:0] cur_max;
  logic [7:0] frame_buf [64];

  lcfd_rx_if  rx_ch();
  lcfd_pay_if pay_ch();

  length_crc32_frame_deframer #(.BUFFER_BYTES(64)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .rx      (rx_ch),
    .payload (pay_ch)
  );

  length_crc32_frame_deframer_checker #(.BUFFER_BYTES(64)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .rx_valid  (rx_ch.valid),
    .rx_ready  (rx_ch.ready),
    .rx_byte   (rx_ch.rx_byte),
    .pay_valid (pay_ch.valid),
    .pay_ready (pay_ch.ready),
    .pay_byte  (pay_ch.payload_byte),
    .pay_index (pay_ch.payload_index),
    .pay_last  (pay_ch.last_of_frame),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Receiver: random ready, or one long hold-off counted here on request.
  always begin
    @(negedge clk);
    if (hold_asked != hold_done) begin
      pay_ch.ready = 1'b0;
      repeat (600) @(negedge clk);
      hold_done++;
    end else begin
      pay_ch.ready = ($urandom_range(99) >= snk_idle);
    end
  end

  // Stimulus-side CRC over the first n bytes of the frame buffer.
  function automatic logic [31:0] stim_crc(input int n);
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      c = c ^ {24'd0, frame_buf[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c ^ CRC_XOROUT;
  endfunction

  // One beat on the rx channel; gaps are taken ahead of it.
  task automatic send_beat(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      rx_ch.valid = 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Frame of plen payload bytes. fill: 0 random, 1 all zero, 2 all ones.
  // A nonzero crc_flip corrupts the trailer.
  task automatic send_frame(input int plen, input int fill, input logic [31:0] crc_flip);
    logic [31:0] flen, crc;
    int          n;
    flen = plen + HDR_BYTES + CRC_BYTES;
    frame_buf[0] = flen[31:24];
    frame_buf[1] = flen[23:16];
    frame_buf[2] = flen[15:8];
    frame_buf[3] = flen[7:0];
    n = 4;
    for (int i = 0; i < plen; i++) begin
      frame_buf[n] = fill == 1 ? 8'h00 : fill == 2 ? 8'hFF : 8'($urandom);
      n++;
    end
    crc = stim_crc(n) ^ crc_flip;
    frame_buf[n]   = crc[31:24];
    frame_buf[n+1] = crc[23:16];
    frame_buf[n+2] = crc[15:8];
    frame_buf[n+3] = crc[7:0];
    n = n + 4;
    for (int i = 0; i < n; i++) send_beat(frame_buf[i]);
  endtask

  // Sender pauses until all payload is out and the block is back to idle.
  task automatic drain();
    @(negedge clk);
    rx_ch.valid = 1'b0;
    @(posedge clk);
    while (pending != 0 || !rx_ch.ready) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_max(input logic [6:0] v);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    cur_max  = v;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Random stream: mostly good frames, some corrupt, some noise.
  task automatic random_phase(input int nbytes);
    int pmax, sel, plen, stop_at;
    logic [31:0] bogus;
    stop_at = sent_bytes + nbytes;
    pmax = (cur_max > 64 ? 64 : cur_max) - 8;
    if (pmax < 1) pmax = 4;
    while (sent_bytes < stop_at) begin
      sel  = $urandom_range(99);
      plen = ($urandom_range(9) == 0) ? pmax : $urandom_range(1, pmax < 12 ? pmax : 12);
      if (sel < 70) send_frame(plen, 0, 32'd0);
      else if (sel < 80) send_frame(plen, 0, 32'd1 << $urandom_range(31));
      else if (sel < 90) repeat ($urandom_range(1, 5)) send_beat(8'($urandom));
      else begin
        // header that can never be valid, then junk
        bogus = $urandom_range(1) ? {8'($urandom | 1), 24'($urandom)} : 32'(65 + $urandom_range(60));
        send_beat(bogus[31:24]); send_beat(bogus[23:16]);
        send_beat(bogus[15:8]);  send_beat(bogus[7:0]);
        repeat ($urandom_range(0, 4)) send_beat(8'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    pay_ch.ready = 1'b0;
    hold_asked = 0;
    sent_bytes = 0;
    cur_max = MAX_LEN_RESET;
    src_idle = 35;
    snk_idle = 65;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: minimum frame with zero and all-ones payloads, largest frame,
    // header with high bytes set, corrupt trailer, noise bytes.
    set_max(7'd64);
    send_frame(1, 1, 32'd0);
    send_frame(1, 2, 32'd0);
    send_beat(8'hFF); send_beat(8'hFF); send_beat(8'hFF); send_beat(8'h09);
    send_frame(2, 0, 32'h8000_0000);
    send_beat(8'h00);
    send_frame(56, 0, 32'd0);
    drain();

    // Phase A: slow sender, slower receiver, plus one long stall so the
    // block backs up and stops taking bytes.
    set_max(7'd127);
    fork
      random_phase(40);
      begin
        repeat (200) @(posedge clk);
        hold_asked++;
      end
    join
    drain();

    // Phase B: idle ratios swapped, tight maximum.
    src_idle = 65;
    snk_idle = 35;
    set_max(7'd20);
    random_phase(35);
    drain();

    // Phase C onward: no idling. Smallest legal maximum, then below it.
    src_idle = 0;
    snk_idle = 0;
    set_max(7'd9);
    random_phase(30);
    drain();
    set_max(7'd8);
    random_phase(25);
    drain();
    set_max(7'd64);
    random_phase(50);
    drain();

    if (fail_count == 0) $display("** length_crc32_frame_deframer: PASSED **");
    else $display("** length_crc32_frame_deframer: FAILED **");
    $finish;
  end

  initial begin
    #8ms;
    $display("** length_crc32_frame_deframer: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/lcfd_pkg.sv
hw/rtl/lcfd_if.sv
hw/rtl/lcfd_crc.sv
hw/rtl/length_crc32_frame_deframer.sv
sim/length_crc32_frame_deframer_checker.sv
sim/length_crc32_frame_deframer_tb.sv
